@@ design/vgrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_pkg
// Shared constants, codes and helpers for the voxel grid ray carve block.
// ----------------------------------------------------------------------------
package vgrc_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 32;

  localparam int X_W    = 6;
  localparam int Y_W    = 6;
  localparam int Z_W    = 5;
  localparam int CELL_W = 2;

  localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int C_MAX  = (X_W > Y_W) ? ((X_W > Z_W) ? X_W : Z_W)
                                      : ((Y_W > Z_W) ? Y_W : Z_W);
  localparam int ACC_W  = 2 * C_MAX + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELIM_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ELIM_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ELIM_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELIM_Z   = 3'd6;

  localparam logic [1:0] FUNC_WRITE    = 2'd0;
  localparam logic [1:0] FUNC_READ     = 2'd1;
  localparam logic [1:0] FUNC_CARVE    = 2'd2;
  localparam logic [1:0] FUNC_FRONTIER = 2'd3;

  localparam logic [CELL_W-1:0] CS_UNKNOWN      = 2'd0;
  localparam logic [CELL_W-1:0] CS_OCCUPIED     = 2'd1;
  localparam logic [CELL_W-1:0] CS_FREE         = 2'd2;
  localparam logic [CELL_W-1:0] CS_NOT_FRONTIER = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_RANGE     = 2'd1;
  localparam logic [1:0] STAT_NOT_OCC   = 2'd2;
  localparam logic [1:0] STAT_ORIGIN    = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
  } dda_ctrl_t;

  function automatic logic in_grid(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                   input logic [Z_W-1:0] z);
    return (32'(x) < GRID_X) && (32'(y) < GRID_Y) && (32'(z) < GRID_Z);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y,
                                                  input logic [Z_W-1:0] z);
    return ADDR_W'(x) + ADDR_W'(GRID_X) * (ADDR_W'(y) + ADDR_W'(GRID_Y) * ADDR_W'(z));
  endfunction

endpackage

@@ design/voxel_grid_ray_carve_frontier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_ray_carve_frontier
// Voxel occupancy grid with ray carving and frontier test.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write cfg_data into register cfg_index while cfg_we is
//   high (0..2 carve origin, 3 elimination enable, 4..6 viewpoint). Write
//   only while busy is low.
//   Commands: present func, cell_x/y/z and new_value with start high; the
//   transaction is taken at an edge where busy is low. busy stays high until
//   the result goes out; done pulses high for one cycle with cell_value,
//   reached, is_frontier and status. The receiver cannot stall: take the
//   result in that cycle.
//   Sequencing: write and read finish from S_TGT; a range error is answered
//   on acceptance. A carve or elimination walk takes each visited cell
//   through S_WRD (memory read), then S_WEV (evaluate, write back and step).
//   A frontier test reads the cell and its six neighbours, one read each,
//   before any walk.
//   Reset: rst clears control and registers, then a clearing pass writes
//   every cell of the 64x64x32 grid unknown, one cell a cycle;
//   busy is high throughout, configuration writes are taken.
// ----------------------------------------------------------------------------
module voxel_grid_ray_carve_frontier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vgrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vgrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func,
  input  logic [vgrc_pkg::X_W-1:0]        cell_x,
  input  logic [vgrc_pkg::Y_W-1:0]        cell_y,
  input  logic [vgrc_pkg::Z_W-1:0]        cell_z,
  input  logic [vgrc_pkg::CELL_W-1:0]     new_value,
  output logic                            done,
  output logic [vgrc_pkg::CELL_W-1:0]     cell_value,
  output logic                            reached,
  output logic                            is_frontier,
  output logic [1:0]                      status
);

  localparam int XW = vgrc_pkg::X_W;
  localparam int YW = vgrc_pkg::Y_W;
  localparam int ZW = vgrc_pkg::Z_W;
  localparam int AW = vgrc_pkg::ADDR_W;
  localparam int CW = vgrc_pkg::CELL_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TGT   = 6'b000100,
    S_NB    = 6'b001000,
    S_WRD   = 6'b010000,
    S_WEV   = 6'b100000
  } state_t;

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] addr;
  } nb_t;

  state_t state;

  // configuration
  logic [XW-1:0] origin_x, elim_x;
  logic [YW-1:0] origin_y, elim_y;
  logic [ZW-1:0] origin_z, elim_z;
  logic          elim_enable;

  // latched command
  logic [1:0]    op;
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  logic [ZW-1:0] tz;
  logic [CW-1:0] nv;
  logic [AW-1:0] tgt_addr;
  logic          carve;
  logic [2:0]    nb_idx;
  logic          zfree, xyfree;
  logic [AW-1:0] clr_addr;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, cur_addr;
  logic [CW-1:0] ram_wdata, rdata;

  // stepper
  vgrc_pkg::dda_ctrl_t dctl;
  logic [XW-1:0] dsx, cx;
  logic [YW-1:0] dsy, cy;
  logic [ZW-1:0] dsz, cz;
  logic          at_end;

  logic accept, cell_ok, org_ok, elim_ok;
  logic tgt_carve_go, nb_last, zf_n, xyf_n, front_n, nb_elim_go, occ, wev_stop;
  nb_t  nb_cur, nb_nxt, nb_first;

  // Neighbour order: z-1, z+1, x-1, x+1, y-1, y+1.
  function automatic nb_t nb_pos(input logic [2:0] idx, input logic [XW-1:0] x,
                                 input logic [YW-1:0] y, input logic [ZW-1:0] z);
    logic [XW:0] nx;
    logic [YW:0] ny;
    logic [ZW:0] nz;
    nb_t         r;
    nx = {1'b0, x};
    ny = {1'b0, y};
    nz = {1'b0, z};
    unique case (idx)
      3'd0:    nz = nz - 1'b1;
      3'd1:    nz = nz + 1'b1;
      3'd2:    nx = nx - 1'b1;
      3'd3:    nx = nx + 1'b1;
      3'd4:    ny = ny - 1'b1;
      3'd5:    ny = ny + 1'b1;
      default: nz = {1'b0, z};
    endcase
    // underflow wraps to a value at or above the grid size
    r.ok   = (32'(nx) < vgrc_pkg::GRID_X) && (32'(ny) < vgrc_pkg::GRID_Y) &&
             (32'(nz) < vgrc_pkg::GRID_Z);
    r.addr = vgrc_pkg::cell_addr(nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]);
    return r;
  endfunction

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign cell_ok = vgrc_pkg::in_grid(cell_x, cell_y, cell_z);
  assign org_ok  = vgrc_pkg::in_grid(origin_x, origin_y, origin_z);
  assign elim_ok = vgrc_pkg::in_grid(elim_x, elim_y, elim_z);

  assign nb_cur   = nb_pos(nb_idx, tx, ty, tz);
  assign nb_nxt   = nb_pos(nb_idx + 3'd1, tx, ty, tz);
  assign nb_first = nb_pos(3'd0, tx, ty, tz);

  // Decisions taken on the data returned by the memory this cycle
  assign tgt_carve_go = (op == vgrc_pkg::FUNC_CARVE) && org_ok &&
                        (rdata == vgrc_pkg::CS_OCCUPIED);
  assign nb_last    = (nb_idx == 3'd5);
  assign zf_n       = zfree  || ((nb_idx < 3'd2) && nb_cur.ok &&
                                 (rdata == vgrc_pkg::CS_FREE));
  assign xyf_n      = xyfree || ((nb_idx >= 3'd2) && nb_cur.ok &&
                                 (rdata == vgrc_pkg::CS_FREE));
  assign front_n    = !zf_n && xyf_n;
  assign nb_elim_go = nb_last && front_n && elim_enable && elim_ok;
  assign occ        = (rdata == vgrc_pkg::CS_OCCUPIED);
  assign wev_stop   = at_end || occ;
  assign cur_addr   = vgrc_pkg::cell_addr(cx, cy, cz);

  // Stepper control: load from the carve origin or the viewpoint
  always_comb begin
    dctl.load = ((state == S_TGT) && tgt_carve_go) || ((state == S_NB) && nb_elim_go);
    dctl.step = (state == S_WEV) && !wev_stop;
    dsx = (state == S_TGT) ? origin_x : elim_x;
    dsy = (state == S_TGT) ? origin_y : elim_y;
    dsz = (state == S_TGT) ? origin_z : elim_z;
  end

  // Memory port: read one cell, write back one cell
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = vgrc_pkg::CS_FREE;
    ram_raddr = cur_addr;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = vgrc_pkg::CS_UNKNOWN;
      end
      S_IDLE: begin
        ram_raddr = vgrc_pkg::cell_addr(cell_x, cell_y, cell_z);
      end
      S_TGT: begin
        ram_we    = (op == vgrc_pkg::FUNC_WRITE);
        ram_waddr = tgt_addr;
        ram_wdata = nv;
        ram_raddr = nb_first.addr;
      end
      S_NB: begin
        ram_raddr = nb_nxt.addr;
      end
      S_WRD: begin
        ram_raddr = cur_addr;
      end
      S_WEV: begin
        // carve frees every cell short of an obstacle; a sighted target
        // is marked not frontier
        ram_we    = carve ? !occ : at_end;
        ram_wdata = carve ? vgrc_pkg::CS_FREE : vgrc_pkg::CS_NOT_FRONTIER;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  vgrc_ram #(
    .WIDTH(CW),
    .DEPTH(vgrc_pkg::DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  vgrc_dda u_dda (
    .clk   (clk),
    .ctrl  (dctl),
    .sx    (dsx),
    .sy    (dsy),
    .sz    (dsz),
    .ex    (tx),
    .ey    (ty),
    .ez    (tz),
    .cx    (cx),
    .cy    (cy),
    .cz    (cz),
    .at_end(at_end)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      elim_enable <= 1'b0;
      elim_x      <= '0;
      elim_y      <= '0;
      elim_z      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgrc_pkg::REG_ORIGIN_X: origin_x    <= cfg_data[XW-1:0];
        vgrc_pkg::REG_ORIGIN_Y: origin_y    <= cfg_data[YW-1:0];
        vgrc_pkg::REG_ORIGIN_Z: origin_z    <= cfg_data[ZW-1:0];
        vgrc_pkg::REG_ELIM_EN:  elim_enable <= cfg_data[0];
        vgrc_pkg::REG_ELIM_X:   elim_x      <= cfg_data[XW-1:0];
        vgrc_pkg::REG_ELIM_Y:   elim_y      <= cfg_data[YW-1:0];
        vgrc_pkg::REG_ELIM_Z:   elim_z      <= cfg_data[ZW-1:0];
        default:                elim_enable <= elim_enable;
      endcase
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(vgrc_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op          <= func;
            tx          <= cell_x;
            ty          <= cell_y;
            tz          <= cell_z;
            nv          <= new_value;
            tgt_addr    <= vgrc_pkg::cell_addr(cell_x, cell_y, cell_z);
            cell_value  <= vgrc_pkg::CS_UNKNOWN;
            reached     <= 1'b0;
            is_frontier <= 1'b0;
            status      <= vgrc_pkg::STAT_OK;
            if (!cell_ok) begin
              // answer at once: origin fault outranks the range fault
              done   <= 1'b1;
              status <= ((func == vgrc_pkg::FUNC_CARVE) && !org_ok) ?
                        vgrc_pkg::STAT_ORIGIN : vgrc_pkg::STAT_RANGE;
            end else begin
              state <= S_TGT;
            end
          end
        end
        S_TGT: begin
          unique case (op)
            vgrc_pkg::FUNC_WRITE: begin
              cell_value <= nv;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
            vgrc_pkg::FUNC_READ: begin
              cell_value <= rdata;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
            vgrc_pkg::FUNC_CARVE: begin
              cell_value <= rdata;
              if (tgt_carve_go) begin
                carve <= 1'b1;
                state <= S_WRD;
              end else begin
                status <= !org_ok ? vgrc_pkg::STAT_ORIGIN : vgrc_pkg::STAT_NOT_OCC;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            default: begin
              cell_value <= rdata;
              if (rdata == vgrc_pkg::CS_UNKNOWN) begin
                nb_idx <= 3'd0;
                zfree  <= 1'b0;
                xyfree <= 1'b0;
                state  <= S_NB;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_NB: begin
          zfree  <= zf_n;
          xyfree <= xyf_n;
          nb_idx <= nb_idx + 3'd1;
          if (nb_last) begin
            if (nb_elim_go) begin
              carve <= 1'b0;
              state <= S_WRD;
            end else begin
              is_frontier <= front_n;
              if (front_n && elim_enable) begin
                status <= vgrc_pkg::STAT_ORIGIN;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_WRD: begin
          state <= S_WEV;
        end
        S_WEV: begin
          if (wev_stop) begin
            if (carve) begin
              reached <= at_end;
            end else if (at_end) begin
              cell_value <= vgrc_pkg::CS_NOT_FRONTIER;
            end else begin
              is_frontier <= 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_WRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/vgrc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vgrc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/vgrc_dda.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_dda
// 3D voxel stepper: exact crossing order by incremental cross products.
// ----------------------------------------------------------------------------
module vgrc_dda (
  input  logic                      clk,
  input  vgrc_pkg::dda_ctrl_t       ctrl,
  input  logic [vgrc_pkg::X_W-1:0]  sx,
  input  logic [vgrc_pkg::Y_W-1:0]  sy,
  input  logic [vgrc_pkg::Z_W-1:0]  sz,
  input  logic [vgrc_pkg::X_W-1:0]  ex,
  input  logic [vgrc_pkg::Y_W-1:0]  ey,
  input  logic [vgrc_pkg::Z_W-1:0]  ez,
  output logic [vgrc_pkg::X_W-1:0]  cx,
  output logic [vgrc_pkg::Y_W-1:0]  cy,
  output logic [vgrc_pkg::Z_W-1:0]  cz,
  output logic                      at_end
);

  localparam int AW = vgrc_pkg::ACC_W;

  logic [vgrc_pkg::X_W-1:0] tx, dx;
  logic [vgrc_pkg::Y_W-1:0] ty, dy;
  logic [vgrc_pkg::Z_W-1:0] tz, dz;
  logic                     px, py, pz;
  // (k_a + 1) * d_b for each ordered pair of axes
  logic [AW-1:0] axy, axz, ayx, ayz, azx, azy;
  logic          e_xy, e_xz, e_yz, mv_x, mv_y;

  assign at_end = (cx == tx) && (cy == ty) && (cz == tz);

  assign e_xy = (dx != '0) && ((dy == '0) || (axy < ayx));
  assign e_xz = (dx != '0) && ((dz == '0) || (axz < azx));
  assign e_yz = (dy != '0) && ((dz == '0) || (ayz < azy));
  assign mv_x = e_xy && e_xz;
  assign mv_y = !e_xy && e_yz;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cx  <= sx;
      cy  <= sy;
      cz  <= sz;
      tx  <= ex;
      ty  <= ey;
      tz  <= ez;
      px  <= (ex >= sx);
      py  <= (ey >= sy);
      pz  <= (ez >= sz);
      dx  <= (ex >= sx) ? ex - sx : sx - ex;
      dy  <= (ey >= sy) ? ey - sy : sy - ey;
      dz  <= (ez >= sz) ? ez - sz : sz - ez;
      axy <= AW'((ey >= sy) ? ey - sy : sy - ey);
      axz <= AW'((ez >= sz) ? ez - sz : sz - ez);
      ayx <= AW'((ex >= sx) ? ex - sx : sx - ex);
      ayz <= AW'((ez >= sz) ? ez - sz : sz - ez);
      azx <= AW'((ex >= sx) ? ex - sx : sx - ex);
      azy <= AW'((ey >= sy) ? ey - sy : sy - ey);
    end else if (ctrl.step) begin
      if (mv_x) begin
        cx  <= px ? cx + 1'b1 : cx - 1'b1;
        axy <= axy + AW'(dy);
        axz <= axz + AW'(dz);
      end else if (mv_y) begin
        cy  <= py ? cy + 1'b1 : cy - 1'b1;
        ayx <= ayx + AW'(dx);
        ayz <= ayz + AW'(dz);
      end else begin
        cz  <= pz ? cz + 1'b1 : cz - 1'b1;
        azx <= azx + AW'(dx);
        azy <= azy + AW'(dy);
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel grid ray carve testbench
// Drives write, read, carve and frontier commands into the voxel grid and
// checks every result against a cycle-free model of the grid, the voxel walk
// and the frontier rule, across several origin and viewpoint settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 400000;   // covers the clearing pass after reset
  localparam int PHASES     = 6;
  localparam int PER_PHASE  = 125;

  typedef struct {
    logic [1:0]                  op;
    logic [vgrc_pkg::X_W-1:0]    x;
    logic [vgrc_pkg::Y_W-1:0]    y;
    logic [vgrc_pkg::Z_W-1:0]    z;
    logic [vgrc_pkg::CELL_W-1:0] nv;
  } command_t;

  typedef struct {
    logic [vgrc_pkg::CELL_W-1:0] value;
    logic                        hit;
    logic                        front;
    logic [1:0]                  stat;
  } outcome_t;

  logic                            clk, rst;
  logic                            cfg_we;
  logic [vgrc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vgrc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            start, busy, done;
  logic [1:0]                      func;
  logic [vgrc_pkg::X_W-1:0]        cell_x;
  logic [vgrc_pkg::Y_W-1:0]        cell_y;
  logic [vgrc_pkg::Z_W-1:0]        cell_z;
  logic [vgrc_pkg::CELL_W-1:0]     new_value;
  logic [vgrc_pkg::CELL_W-1:0]     cell_value;
  logic                            reached, is_frontier;
  logic [1:0]                      status;

  voxel_grid_ray_carve_frontier dut (.*);

  // Model state: the grid and a shadow of the configuration registers
  logic [vgrc_pkg::CELL_W-1:0] cell_map [0:vgrc_pkg::DEPTH-1];
  int                org_x, org_y, org_z, vp_x, vp_y, vp_z;
  bit                elim_on;

  command_t pending [$];
  outcome_t results_due [$];
  int       acc_count, seen_count, gap_left, idle_cycles, fail_count;
  bit       no_idle;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic bit on_grid(int x, int y, int z);
    return x >= 0 && x < vgrc_pkg::GRID_X && y >= 0 && y < vgrc_pkg::GRID_Y &&
           z >= 0 && z < vgrc_pkg::GRID_Z;
  endfunction

  function automatic int map_idx(int x, int y, int z);
    return x + vgrc_pkg::GRID_X * (y + vgrc_pkg::GRID_Y * z);
  endfunction

  function automatic logic [vgrc_pkg::CELL_W-1:0] peek(int x, int y, int z);
    return on_grid(x, y, z) ? cell_map[map_idx(x, y, z)] : vgrc_pkg::CS_UNKNOWN;
  endfunction

  function automatic bit free_at(int x, int y, int z);
    return on_grid(x, y, z) && cell_map[map_idx(x, y, z)] == vgrc_pkg::CS_FREE;
  endfunction

  // Strictly earlier boundary crossing; an axis that does not move never crosses
  function automatic bit crosses_first(int ka, int da, int kb, int db);
    if (da == 0) return 0;
    if (db == 0) return 1;
    return (ka + 1) * db < (kb + 1) * da;
  endfunction

  // Voxel walk from s to e; stops on e or on an occupied cell, freeing on a carve
  function automatic bit trace_ray(int sx, int sy, int sz, int ex, int ey, int ez,
                                   bit carve);
    int cx, cy, cz, stx, sty, stz, dx, dy, dz, kx, ky, kz;
    bit at_end, occ;
    cx = sx; cy = sy; cz = sz;
    stx = (ex > sx) - (ex < sx);
    sty = (ey > sy) - (ey < sy);
    stz = (ez > sz) - (ez < sz);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    dz = (ez > sz) ? ez - sz : sz - ez;
    kx = 0; ky = 0; kz = 0;
    for (int n = 0; n < dx + dy + dz + 1; n++) begin
      at_end = (cx == ex && cy == ey && cz == ez);
      occ = peek(cx, cy, cz) == vgrc_pkg::CS_OCCUPIED;
      if (carve && !occ && on_grid(cx, cy, cz))
        cell_map[map_idx(cx, cy, cz)] = vgrc_pkg::CS_FREE;
      if (at_end || occ) return at_end;
      if (crosses_first(kx, dx, ky, dy)) begin
        if (crosses_first(kx, dx, kz, dz)) begin cx += stx; kx++; end
        else begin cz += stz; kz++; end
      end else begin
        if (crosses_first(ky, dy, kz, dz)) begin cy += sty; ky++; end
        else begin cz += stz; kz++; end
      end
      if (!on_grid(cx, cy, cz)) return 0;
    end
    return 0;
  endfunction

  function automatic outcome_t predict_command(command_t c);
    outcome_t r;
    int x, y, z;
    bit ok;
    x = c.x; y = c.y; z = c.z;
    ok = on_grid(x, y, z);
    r = '{value: vgrc_pkg::CS_UNKNOWN, hit: 0, front: 0, stat: vgrc_pkg::STAT_OK};
    if (c.op == vgrc_pkg::FUNC_CARVE) begin
      if (!on_grid(org_x, org_y, org_z)) begin
        r.stat = vgrc_pkg::STAT_ORIGIN;
        r.value = peek(x, y, z);
      end else if (!ok) begin
        r.stat = vgrc_pkg::STAT_RANGE;
      end else if (peek(x, y, z) != vgrc_pkg::CS_OCCUPIED) begin
        r.stat = vgrc_pkg::STAT_NOT_OCC;
        r.value = peek(x, y, z);
      end else begin
        r.hit = trace_ray(org_x, org_y, org_z, x, y, z, 1);
        r.value = peek(x, y, z);
      end
    end else if (!ok) begin
      r.stat = vgrc_pkg::STAT_RANGE;
    end else if (c.op == vgrc_pkg::FUNC_WRITE) begin
      cell_map[map_idx(x, y, z)] = c.nv;
      r.value = c.nv;
    end else if (c.op == vgrc_pkg::FUNC_READ) begin
      r.value = peek(x, y, z);
    end else begin
      if (peek(x, y, z) == vgrc_pkg::CS_UNKNOWN &&
          !free_at(x, y, z - 1) && !free_at(x, y, z + 1) &&
          (free_at(x - 1, y, z) || free_at(x + 1, y, z) ||
           free_at(x, y - 1, z) || free_at(x, y + 1, z))) begin
        r.front = 1;
        if (elim_on) begin
          if (!on_grid(vp_x, vp_y, vp_z)) r.stat = vgrc_pkg::STAT_ORIGIN;
          else if (trace_ray(vp_x, vp_y, vp_z, x, y, z, 0)) begin
            cell_map[map_idx(x, y, z)] = vgrc_pkg::CS_NOT_FRONTIER;
            r.front = 0;
          end
        end
      end
      r.value = peek(x, y, z);
    end
    return r;
  endfunction

  // Monitor: retire the result first, then log any new transaction
  always @(posedge clk) begin
    command_t c;
    outcome_t e;
    if (done) begin
      if (results_due.size() == 0) begin
        $error("result with none outstanding");
        fail_count++;
      end else begin
        e = results_due.pop_front();
        if (cell_value !== e.value) begin
          $error("cell_value: expected %0d, got %0d", e.value, cell_value); fail_count++;
        end
        if (reached !== e.hit) begin
          $error("reached: expected %0d, got %0d", e.hit, reached); fail_count++;
        end
        if (is_frontier !== e.front) begin
          $error("is_frontier: expected %0d, got %0d", e.front, is_frontier); fail_count++;
        end
        if (status !== e.stat) begin
          $error("status: expected %0d, got %0d", e.stat, status); fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      c = '{op: func, x: cell_x, y: cell_y, z: cell_z, nv: new_value};
      results_due.insert(results_due.size(), predict_command(c));
      acc_count++;
    end
    // Watchdog: count edges with nothing moving
    if (done || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: hold a command until taken, then idle for a drawn gap
  always @(negedge clk) begin
    command_t c;
    if (!(start && acc_count == seen_count)) begin
      if (start) begin
        seen_count = acc_count;
        gap_left = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        c = pending.pop_front();
        func <= c.op; cell_x <= c.x; cell_y <= c.y; cell_z <= c.z; new_value <= c.nv;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, int x, int y, int z, int nv);
    command_t c;
    c = '{op: op, x: vgrc_pkg::X_W'(x), y: vgrc_pkg::Y_W'(y), z: vgrc_pkg::Z_W'(z),
          nv: vgrc_pkg::CELL_W'(nv)};
    pending.insert(pending.size(), c);
  endtask

  // Write a register while the block is idle and mirror it in the model
  task automatic write_reg(logic [vgrc_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= vgrc_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vgrc_pkg::REG_ORIGIN_X: org_x = val;
      vgrc_pkg::REG_ORIGIN_Y: org_y = val;
      vgrc_pkg::REG_ORIGIN_Z: org_z = val;
      vgrc_pkg::REG_ELIM_EN:  elim_on = val[0];
      vgrc_pkg::REG_ELIM_X:   vp_x = val;
      vgrc_pkg::REG_ELIM_Y:   vp_y = val;
      default:                vp_z = val;
    endcase
  endtask

  task automatic drain();
    while (pending.size() > 0 || start || results_due.size() > 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly a small cluster so rays and neighbours interact; now and then anywhere
  task automatic pick_cell(output int x, output int y, output int z);
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 63); y = $urandom_range(0, 63); z = $urandom_range(0, 31);
    end else begin
      x = $urandom_range(26, 37); y = $urandom_range(26, 37); z = $urandom_range(12, 19);
    end
  endtask

  task automatic add_random();
    int x, y, z, bx, by, bz, kind;
    kind = $urandom_range(0, 99);
    pick_cell(x, y, z);
    if (kind < 30) begin
      // carve to an occupied target, sometimes with a second occupied cell that may lie in the way
      if ($urandom_range(0, 2) == 0) begin
        pick_cell(bx, by, bz);
        add_cmd(vgrc_pkg::FUNC_WRITE, bx, by, bz, vgrc_pkg::CS_OCCUPIED);
      end
      add_cmd(vgrc_pkg::FUNC_WRITE, x, y, z, vgrc_pkg::CS_OCCUPIED);
      add_cmd(vgrc_pkg::FUNC_CARVE, x, y, z, $urandom_range(0, 3));
    end else if (kind < 60) begin
      // frontier candidate: free side neighbour, maybe a free z neighbour
      if (x < 63) add_cmd(vgrc_pkg::FUNC_WRITE, x + 1, y, z, vgrc_pkg::CS_FREE);
      if ($urandom_range(0, 3) == 0 && z > 0)
        add_cmd(vgrc_pkg::FUNC_WRITE, x, y, z - 1, vgrc_pkg::CS_FREE);
      if ($urandom_range(0, 3) != 0)
        add_cmd(vgrc_pkg::FUNC_WRITE, x, y, z, vgrc_pkg::CS_UNKNOWN);
      add_cmd(vgrc_pkg::FUNC_FRONTIER, x, y, z, $urandom_range(0, 3));
    end else begin
      add_cmd(2'($urandom_range(0, 3)), x, y, z, $urandom_range(0, 3));
    end
  endtask

  initial begin
    int total;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    start = 1'b0; func = vgrc_pkg::FUNC_READ; cell_x = '0; cell_y = '0; cell_z = '0;
    new_value = vgrc_pkg::CS_UNKNOWN;
    acc_count = 0; seen_count = 0; gap_left = 0; idle_cycles = 0; fail_count = 0;
    no_idle = 0;
    org_x = 0; org_y = 0; org_z = 0; vp_x = 0; vp_y = 0; vp_z = 0; elim_on = 0;
    for (int i = 0; i < vgrc_pkg::DEPTH; i++) cell_map[i] = vgrc_pkg::CS_UNKNOWN;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: corner cells, every state, long carve, unoccupied target, frontiers
    add_cmd(vgrc_pkg::FUNC_WRITE, 63, 63, 31, vgrc_pkg::CS_OCCUPIED);
    add_cmd(vgrc_pkg::FUNC_READ, 63, 63, 31, vgrc_pkg::CS_FREE);
    add_cmd(vgrc_pkg::FUNC_CARVE, 63, 63, 31, vgrc_pkg::CS_NOT_FRONTIER);
    add_cmd(vgrc_pkg::FUNC_READ, 0, 0, 0, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_READ, 32, 32, 16, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_CARVE, 10, 20, 5, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_WRITE, 0, 0, 0, vgrc_pkg::CS_NOT_FRONTIER);
    add_cmd(vgrc_pkg::FUNC_WRITE, 0, 0, 0, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_WRITE, 5, 5, 3, vgrc_pkg::CS_OCCUPIED);
    add_cmd(vgrc_pkg::FUNC_WRITE, 10, 10, 6, vgrc_pkg::CS_OCCUPIED);
    add_cmd(vgrc_pkg::FUNC_CARVE, 10, 10, 6, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_WRITE, 20, 20, 10, vgrc_pkg::CS_FREE);
    add_cmd(vgrc_pkg::FUNC_FRONTIER, 21, 20, 10, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_WRITE, 21, 20, 9, vgrc_pkg::CS_FREE);
    add_cmd(vgrc_pkg::FUNC_FRONTIER, 19, 20, 10, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_FRONTIER, 20, 21, 9, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_FRONTIER, 40, 40, 20, vgrc_pkg::CS_UNKNOWN);
    add_cmd(vgrc_pkg::FUNC_FRONTIER, 20, 20, 10, vgrc_pkg::CS_UNKNOWN);
    drain();

    // Phases: extremes first, then random settings; elimination on for most
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(vgrc_pkg::REG_ORIGIN_X, 63);
          write_reg(vgrc_pkg::REG_ORIGIN_Y, 63);
          write_reg(vgrc_pkg::REG_ORIGIN_Z, 31);
          write_reg(vgrc_pkg::REG_ELIM_EN, 1);
          write_reg(vgrc_pkg::REG_ELIM_X, 0);
          write_reg(vgrc_pkg::REG_ELIM_Y, 0);
          write_reg(vgrc_pkg::REG_ELIM_Z, 0);
        end
        1: begin
          write_reg(vgrc_pkg::REG_ORIGIN_X, 0);
          write_reg(vgrc_pkg::REG_ORIGIN_Y, 0);
          write_reg(vgrc_pkg::REG_ORIGIN_Z, 0);
          write_reg(vgrc_pkg::REG_ELIM_X, 63);
          write_reg(vgrc_pkg::REG_ELIM_Y, 63);
          write_reg(vgrc_pkg::REG_ELIM_Z, 31);
        end
        2: write_reg(vgrc_pkg::REG_ELIM_EN, 0);
        default: begin
          write_reg(vgrc_pkg::REG_ORIGIN_X, $urandom_range(24, 39));
          write_reg(vgrc_pkg::REG_ORIGIN_Y, $urandom_range(24, 39));
          write_reg(vgrc_pkg::REG_ORIGIN_Z, $urandom_range(10, 21));
          write_reg(vgrc_pkg::REG_ELIM_EN, p != 4);
          write_reg(vgrc_pkg::REG_ELIM_X, $urandom_range(24, 39));
          write_reg(vgrc_pkg::REG_ELIM_Y, $urandom_range(24, 39));
          write_reg(vgrc_pkg::REG_ELIM_Z, $urandom_range(10, 21));
        end
      endcase
      no_idle = (p == 3);
      total = pending.size() + acc_count;
      while (pending.size() + acc_count - total < PER_PHASE) add_random();
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
